/* hdl/rgbenc_pkg.sv */
// shared constants and types for the rgb led chain bit encoder
`timescale 1ns / 1ps
package rgbenc_pkg;

  localparam int LED_COUNT        = 64;
  localparam int RESET_SLOT_COUNT = 50;
  localparam int LED_W            = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int RST_W            = 8;
  localparam int BIT_W            = 5;
  localparam int COLOR_W          = 24;

  localparam logic [8:0]         LED_COUNT_V = 9'(LED_COUNT);
  localparam logic [LED_W-1:0]   LED_LAST    = LED_W'(LED_COUNT - 1);
  localparam logic [RST_W-1:0]   RST_LAST    = RST_W'(RESET_SLOT_COUNT - 1);
  localparam logic [BIT_W-1:0]   BIT_TOP     = 5'd23;
  localparam logic [5:0]         DUTY_ONE    = 6'd60;
  localparam logic [5:0]         DUTY_ZERO   = 6'd30;
  localparam logic [6:0]         FULL_SCALE  = 7'd100;
  // x / 100 == (x * 5243) >> 19 for every x below 25501
  localparam logic [12:0]        RECIP       = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    OP_SET_ONE = 2'd0,
    OP_SET_ALL = 2'd1,
    OP_SHOW    = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRD,
    S_SLAT,
    S_MUL,
    S_DIV,
    S_WR,
    S_TICK
  } state_t;

endpackage

/* hdl/rgbenc_in_if.sv */
// input channel: op and color payload with valid/ready
`timescale 1ns / 1ps
interface rgbenc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, op, led_index, red, green, blue, input ready);
  modport sink   (input valid, op, led_index, red, green, blue, output ready);
endinterface

/* hdl/rgbenc_out_if.sv */
// result channel: duty slot and status with valid/ready
`timescale 1ns / 1ps
interface rgbenc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] duty;
  logic       busy_res;
  logic       accepted;
  logic       frame_done;

  modport source (output valid, duty, busy_res, accepted, frame_done, input ready);
  modport sink   (input valid, duty, busy_res, accepted, frame_done, output ready);
endinterface

/* hdl/rgbenc_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module rgbenc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/rgb_led_chain_bit_encoder.sv */
// rgb led chain bit encoder top level: color store, frame snapshot and slot sequencer
`timescale 1ns / 1ps
// Each input item gives exactly one result. Set one, set all, a refused show, a tick while
// idle and a tick in the trailing reset slots give their result in the cycle after the
// transfer. A tick that sends a data bit first passes through S_TICK, which waits for the
// registered read of the snapshot memory. An accepted show takes the leds in turn:
// per led S_SRD and S_SLAT read the color store, one shared 8x7 multiplier (S_MUL) and one
// reciprocal multiply (S_DIV) scale the three colors in turn, and S_WR writes the scaled
// word into the snapshot. The block takes a new item only once the previous result has been
// transferred. The color store reads as all zeros after reset with no clearing pass;
// brightness writes above 100 are held at 100.
module rgb_led_chain_bit_encoder (
  input  logic            clk,
  input  logic            rst_n,
  rgbenc_in_if.sink       in_ch,
  rgbenc_out_if.source    out_ch,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_wdata
);

  rgbenc_pkg::state_t state_r, state_nxt;
  rgbenc_pkg::op_t    op;

  logic [6:0]                          bright_r, bright_nxt;
  logic [rgbenc_pkg::COLOR_W-1:0]      global_r, global_nxt;
  logic [rgbenc_pkg::LED_COUNT-1:0]    valid_r, valid_nxt;
  logic                                sending_r, sending_nxt;
  logic                                in_reset_r, in_reset_nxt;
  logic [rgbenc_pkg::LED_W-1:0]        led_r, led_nxt;
  logic [rgbenc_pkg::BIT_W-1:0]        bit_r, bit_nxt;
  logic [rgbenc_pkg::RST_W-1:0]        rst_cnt_r, rst_cnt_nxt;
  logic [rgbenc_pkg::LED_W-1:0]        sw_led_r, sw_led_nxt;
  logic [1:0]                          byte_idx_r, byte_idx_nxt;
  logic [rgbenc_pkg::COLOR_W-1:0]      word_r, word_nxt;
  logic [14:0]                         prod_r, prod_nxt;
  logic [rgbenc_pkg::COLOR_W-1:0]      scaled_r, scaled_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [5:0] duty_r, duty_nxt;
  logic       busy_r, busy_nxt;
  logic       acc_r, acc_nxt;
  logic       done_r, done_nxt;

  logic                           in_xfer;
  logic                           idx_ok;
  logic [rgbenc_pkg::COLOR_W-1:0] in_word;
  logic [rgbenc_pkg::LED_W-1:0]   wr_led;
  logic                           store_we;
  logic [rgbenc_pkg::COLOR_W-1:0] store_rdata;
  logic                           snap_we;
  logic [rgbenc_pkg::COLOR_W-1:0] snap_rdata;
  logic [7:0]                     cur_byte;
  logic [27:0]                    div_prod;
  logic [7:0]                     quot;

  assign op       = rgbenc_pkg::op_t'(in_ch.op);
  assign in_ch.ready = (state_r == rgbenc_pkg::S_IDLE) && !out_valid_r;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign idx_ok   = {1'b0, in_ch.led_index} < rgbenc_pkg::LED_COUNT_V;
  assign in_word  = {in_ch.green, in_ch.red, in_ch.blue};
  assign wr_led   = in_ch.led_index[rgbenc_pkg::LED_W-1:0];
  assign store_we = in_xfer && (op == rgbenc_pkg::OP_SET_ONE) && idx_ok;
  assign snap_we  = (state_r == rgbenc_pkg::S_WR);

  // green, red, blue in turn
  always_comb begin
    case (byte_idx_r)
      2'd0:    cur_byte = word_r[23:16];
      2'd1:    cur_byte = word_r[15:8];
      default: cur_byte = word_r[7:0];
    endcase
  end

  assign div_prod = {13'b0, prod_r} * {15'b0, rgbenc_pkg::RECIP};
  assign quot     = div_prod[rgbenc_pkg::RECIP_SHIFT +: 8];

  rgbenc_ram #(.WIDTH(rgbenc_pkg::COLOR_W), .DEPTH(rgbenc_pkg::LED_COUNT)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (wr_led),
    .wdata (in_word),
    .raddr (sw_led_r),
    .rdata (store_rdata)
  );

  rgbenc_ram #(.WIDTH(rgbenc_pkg::COLOR_W), .DEPTH(rgbenc_pkg::LED_COUNT)) u_snap (
    .clk   (clk),
    .we    (snap_we),
    .waddr (sw_led_r),
    .wdata (scaled_r),
    .raddr (led_r),
    .rdata (snap_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    bright_nxt    = bright_r;
    global_nxt    = global_r;
    valid_nxt     = valid_r;
    sending_nxt   = sending_r;
    in_reset_nxt  = in_reset_r;
    led_nxt       = led_r;
    bit_nxt       = bit_r;
    rst_cnt_nxt   = rst_cnt_r;
    sw_led_nxt    = sw_led_r;
    byte_idx_nxt  = byte_idx_r;
    word_nxt      = word_r;
    prod_nxt      = prod_r;
    scaled_nxt    = scaled_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    duty_nxt      = duty_r;
    busy_nxt      = busy_r;
    acc_nxt       = acc_r;
    done_nxt      = done_r;

    if (cfg_we) begin
      bright_nxt = (cfg_wdata > rgbenc_pkg::FULL_SCALE) ? rgbenc_pkg::FULL_SCALE : cfg_wdata;
    end

    case (state_r)
      rgbenc_pkg::S_IDLE: begin
        if (in_xfer) begin
          // default result, overridden where the op takes more cycles
          out_valid_nxt = 1'b1;
          duty_nxt      = 6'd0;
          busy_nxt      = sending_r;
          acc_nxt       = 1'b1;
          done_nxt      = 1'b0;
          case (op)
            rgbenc_pkg::OP_SET_ONE: begin
              if (idx_ok) begin
                valid_nxt[wr_led] = 1'b1;
              end else begin
                acc_nxt = 1'b0;
              end
            end
            rgbenc_pkg::OP_SET_ALL: begin
              // entries without a valid bit read as the broadcast color
              global_nxt = in_word;
              valid_nxt  = '0;
            end
            rgbenc_pkg::OP_SHOW: begin
              if (sending_r) begin
                acc_nxt = 1'b0;
              end else begin
                out_valid_nxt = 1'b0;
                sw_led_nxt    = '0;
                state_nxt     = rgbenc_pkg::S_SRD;
              end
            end
            default: begin
              if (sending_r) begin
                if (!in_reset_r) begin
                  out_valid_nxt = 1'b0;
                  state_nxt     = rgbenc_pkg::S_TICK;
                end else if (rst_cnt_r == rgbenc_pkg::RST_LAST) begin
                  done_nxt     = 1'b1;
                  busy_nxt     = 1'b0;
                  sending_nxt  = 1'b0;
                  in_reset_nxt = 1'b0;
                  rst_cnt_nxt  = '0;
                end else begin
                  rst_cnt_nxt = rst_cnt_r + 1'b1;
                end
              end
            end
          endcase
        end
      end
      rgbenc_pkg::S_SRD: begin
        state_nxt = rgbenc_pkg::S_SLAT;
      end
      rgbenc_pkg::S_SLAT: begin
        word_nxt     = valid_r[sw_led_r] ? store_rdata : global_r;
        byte_idx_nxt = 2'd0;
        state_nxt    = rgbenc_pkg::S_MUL;
      end
      rgbenc_pkg::S_MUL: begin
        prod_nxt  = {7'b0, cur_byte} * {8'b0, bright_r};
        state_nxt = rgbenc_pkg::S_DIV;
      end
      rgbenc_pkg::S_DIV: begin
        scaled_nxt = {scaled_r[15:0], quot};
        if (byte_idx_r == 2'd2) begin
          state_nxt = rgbenc_pkg::S_WR;
        end else begin
          byte_idx_nxt = byte_idx_r + 1'b1;
          state_nxt    = rgbenc_pkg::S_MUL;
        end
      end
      rgbenc_pkg::S_WR: begin
        if (sw_led_r == rgbenc_pkg::LED_LAST) begin
          sending_nxt   = 1'b1;
          in_reset_nxt  = 1'b0;
          led_nxt       = '0;
          bit_nxt       = rgbenc_pkg::BIT_TOP;
          rst_cnt_nxt   = '0;
          out_valid_nxt = 1'b1;
          duty_nxt      = 6'd0;
          busy_nxt      = 1'b1;
          acc_nxt       = 1'b1;
          done_nxt      = 1'b0;
          state_nxt     = rgbenc_pkg::S_IDLE;
        end else begin
          sw_led_nxt = sw_led_r + 1'b1;
          state_nxt  = rgbenc_pkg::S_SRD;
        end
      end
      rgbenc_pkg::S_TICK: begin
        out_valid_nxt = 1'b1;
        duty_nxt      = snap_rdata[bit_r] ? rgbenc_pkg::DUTY_ONE : rgbenc_pkg::DUTY_ZERO;
        busy_nxt      = 1'b1;
        acc_nxt       = 1'b1;
        done_nxt      = 1'b0;
        if (bit_r == '0) begin
          bit_nxt = rgbenc_pkg::BIT_TOP;
          if (led_r == rgbenc_pkg::LED_LAST) begin
            in_reset_nxt = 1'b1;
            led_nxt      = '0;
          end else begin
            led_nxt = led_r + 1'b1;
          end
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
        state_nxt = rgbenc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rgbenc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgbenc_pkg::S_IDLE;
      bright_r    <= rgbenc_pkg::FULL_SCALE;
      global_r    <= '0;
      valid_r     <= '0;
      sending_r   <= 1'b0;
      in_reset_r  <= 1'b0;
      led_r       <= '0;
      bit_r       <= rgbenc_pkg::BIT_TOP;
      rst_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bright_r    <= bright_nxt;
      global_r    <= global_nxt;
      valid_r     <= valid_nxt;
      sending_r   <= sending_nxt;
      in_reset_r  <= in_reset_nxt;
      led_r       <= led_nxt;
      bit_r       <= bit_nxt;
      rst_cnt_r   <= rst_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sw_led_r   <= sw_led_nxt;
    byte_idx_r <= byte_idx_nxt;
    word_r     <= word_nxt;
    prod_r     <= prod_nxt;
    scaled_r   <= scaled_nxt;
    duty_r     <= duty_nxt;
    busy_r     <= busy_nxt;
    acc_r      <= acc_nxt;
    done_r     <= done_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.duty       = duty_r;
  assign out_ch.busy_res   = busy_r;
  assign out_ch.accepted   = acc_r;
  assign out_ch.frame_done = done_r;

endmodule

/* verif/tb_rgb_led_chain_bit_encoder.sv */
// testbench for the rgb led chain bit encoder: random led frames checked against a slot predictor
`timescale 1ns / 1ps
module tb_rgb_led_chain_bit_encoder;

  localparam int LED_COUNT     = rgbenc_pkg::LED_COUNT;
  localparam int LED_W         = rgbenc_pkg::LED_W;
  localparam int BITS_PER_LED  = 24;
  localparam int DATA_SLOTS    = LED_COUNT * BITS_PER_LED;
  localparam int FRAME_SLOTS   = DATA_SLOTS + rgbenc_pkg::RESET_SLOT_COUNT;
  localparam int PERCENT_FULL  = 100;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_TICKS   = 65;

  typedef struct packed {
    rgbenc_pkg::op_t op;
    logic [7:0]      led_index;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
  } led_cmd_t;

  typedef struct packed {
    logic [5:0] duty;
    logic       busy_res;
    logic       accepted;
    logic       frame_done;
  } slot_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  rgbenc_in_if  in_ch();
  rgbenc_out_if out_ch();

  rgb_led_chain_bit_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [23:0] color_store [LED_COUNT];
  logic [23:0] frame_image [LED_COUNT];
  int          slot_pos    = 0;
  bit          sending     = 1'b0;
  int          bright_pct  = PERCENT_FULL;

  led_cmd_t     pending_cmds[$];
  slot_result_t expected_slots[$];
  int           cmds_issued    = 0;
  int           results_seen   = 0;
  int           error_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  bit           in_xfer        = 1'b0;
  bit           hold_arm       = 1'b0;
  bit           hold_used      = 1'b0;
  int           hold_left      = 0;
  wire          hold_off       = (hold_left != 0);

  function automatic logic [7:0] scale_color(logic [7:0] v);
    return 8'((int'(v) * bright_pct) / PERCENT_FULL);
  endfunction

  function automatic slot_result_t predict_slot(led_cmd_t c);
    slot_result_t r;
    logic [23:0]  w;
    int           bit_sel;
    r = '0;
    r.accepted = 1'b1;
    case (c.op)
      rgbenc_pkg::OP_SET_ONE: begin
        if (c.led_index < LED_COUNT)
          color_store[c.led_index[LED_W-1:0]] = {c.green, c.red, c.blue};
        else r.accepted = 1'b0;
      end
      rgbenc_pkg::OP_SET_ALL: begin
        for (int i = 0; i < LED_COUNT; i++) color_store[i] = {c.green, c.red, c.blue};
      end
      rgbenc_pkg::OP_SHOW: begin
        if (sending) begin
          r.accepted = 1'b0;
        end else begin
          for (int i = 0; i < LED_COUNT; i++) begin
            w = color_store[i];
            frame_image[i] = {scale_color(w[23:16]), scale_color(w[15:8]), scale_color(w[7:0])};
          end
          slot_pos = 0;
          sending  = 1'b1;
        end
      end
      default: begin
        if (sending) begin
          if (slot_pos < DATA_SLOTS) begin
            w       = frame_image[LED_W'(slot_pos / BITS_PER_LED)];
            bit_sel = BITS_PER_LED - 1 - slot_pos % BITS_PER_LED;
            r.duty  = w[bit_sel] ? rgbenc_pkg::DUTY_ONE : rgbenc_pkg::DUTY_ZERO;
          end
          if (slot_pos + 1 >= FRAME_SLOTS) begin
            r.frame_done = 1'b1;
            sending      = 1'b0;
            slot_pos     = 0;
          end else begin
            slot_pos++;
          end
        end
      end
    endcase
    r.busy_res = sending;
    return r;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // input transfers feed the predictor, result transfers are checked in order
  always @(posedge clk) begin : monitor
    led_cmd_t     seen;
    slot_result_t got;
    slot_result_t want;
    in_xfer = rst_n && in_ch.valid && in_ch.ready;
    if (in_xfer) begin
      seen.op        = rgbenc_pkg::op_t'(in_ch.op);
      seen.led_index = in_ch.led_index;
      seen.red       = in_ch.red;
      seen.green     = in_ch.green;
      seen.blue      = in_ch.blue;
      expected_slots.push_back(predict_slot(seen));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got.duty       = out_ch.duty;
      got.busy_res   = out_ch.busy_res;
      got.accepted   = out_ch.accepted;
      got.frame_done = out_ch.frame_done;
      if (expected_slots.size() == 0) begin
        error_count++;
        $display({"%0t ns: unexpected result, expected none, ",
                  "actual duty %0d busy %0d acc %0d done %0d"},
                 $time, got.duty, got.busy_res, got.accepted, got.frame_done);
      end else begin
        want = expected_slots.pop_front();
        check_field("duty", want.duty, got.duty);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("accepted", want.accepted, got.accepted);
        check_field("frame_done", want.frame_done, got.frame_done);
      end
    end
  end

  // drives the input channel from the pending queue and the result ready
  always @(negedge clk) begin : driver
    led_cmd_t next_cmd;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      if (!in_ch.valid || in_xfer) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd         = pending_cmds.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.op        <= next_cmd.op;
          in_ch.led_index <= next_cmd.led_index;
          in_ch.red       <= next_cmd.red;
          in_ch.green     <= next_cmd.green;
          in_ch.blue      <= next_cmd.blue;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_used && in_ch.valid) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_color();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    return rand_byte();
  endfunction

  task automatic push_cmd(rgbenc_pkg::op_t op, logic [7:0] idx, logic [7:0] r,
                          logic [7:0] g, logic [7:0] b);
    led_cmd_t c;
    c.op        = op;
    c.led_index = idx;
    c.red       = r;
    c.green     = g;
    c.blue      = b;
    pending_cmds.push_back(c);
    cmds_issued++;
  endtask

  task automatic push_noise();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45)
      push_cmd(rgbenc_pkg::OP_SET_ONE,
               ($urandom_range(1) != 0) ? 8'($urandom_range(LED_COUNT - 1)) : rand_byte(),
               pick_color(), pick_color(), pick_color());
    else if (pick < 60)
      push_cmd(rgbenc_pkg::OP_SET_ALL, rand_byte(), pick_color(), pick_color(), pick_color());
    else if (pick < 75)
      push_cmd(rgbenc_pkg::OP_SHOW, rand_byte(), pick_color(), pick_color(), pick_color());
    else
      push_cmd(rgbenc_pkg::OP_TICK, rand_byte(), pick_color(), pick_color(), pick_color());
  endtask

  // a burst of slot ticks with some other commands mixed in
  task automatic tick_slots(int noise_pct, int count);
    repeat (count) begin
      if ($urandom_range(99) < noise_pct) push_noise();
      else push_cmd(rgbenc_pkg::OP_TICK, rand_byte(), pick_color(), pick_color(),
                    pick_color());
    end
  endtask

  task automatic run_frame(int noise_pct);
    repeat ($urandom_range(20)) push_noise();
    push_cmd(rgbenc_pkg::OP_SHOW, rand_byte(), pick_color(), pick_color(), pick_color());
    tick_slots(noise_pct, PHASE_TICKS);
  endtask

  task automatic drain();
    while (results_seen < cmds_issued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_brightness(int level);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = 7'(level);
    @(negedge clk);
    cfg_we     = 1'b0;
    bright_pct = (level > PERCENT_FULL) ? PERCENT_FULL : level;
  endtask

  task automatic run_phase(int send_pct, int stall_pct, int level);
    drain();
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    set_brightness(level);
    run_frame(5);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.op        = rgbenc_pkg::OP_TICK;
    in_ch.led_index = '0;
    in_ch.red       = '0;
    in_ch.green     = '0;
    in_ch.blue      = '0;
    out_ch.ready    = 1'b0;
    for (int i = 0; i < LED_COUNT; i++) begin
      color_store[i] = '0;
      frame_image[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: idle tick, set extremes, out of range sets, show, refused show,
    // sets during a frame, then the first data slots
    push_cmd(rgbenc_pkg::OP_TICK, 8'hff, 8'hff, 8'hff, 8'hff);
    push_cmd(rgbenc_pkg::OP_SET_ALL, 8'h00, 8'haa, 8'h55, 8'h0f);
    push_cmd(rgbenc_pkg::OP_SET_ONE, 8'h00, 8'hff, 8'hff, 8'hff);
    push_cmd(rgbenc_pkg::OP_SET_ONE, 8'(LED_COUNT - 1), 8'h00, 8'h00, 8'h00);
    push_cmd(rgbenc_pkg::OP_SET_ONE, 8'(LED_COUNT), 8'h12, 8'h34, 8'h56);
    push_cmd(rgbenc_pkg::OP_SET_ONE, 8'hff, 8'hff, 8'hff, 8'hff);
    push_cmd(rgbenc_pkg::OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(rgbenc_pkg::OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(rgbenc_pkg::OP_SET_ONE, 8'h01, 8'h00, 8'hff, 8'h00);
    push_cmd(rgbenc_pkg::OP_SET_ALL, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (15) push_cmd(rgbenc_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);

    run_phase(84, 0, 0);
    run_phase(0, 84, 127);
    run_phase(33, 33, 37);

    // no idling, but one long stall of the result side
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_brightness(1);
    hold_arm = 1'b1;
    run_frame(5);

    run_phase(0, 0, 100);
    drain();

    if (expected_slots.size() != 0) begin
      error_count++;
      $display("%0t ns: %0d expected results never arrived", $time, expected_slots.size());
    end
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
